// ===== rtl/interrupt_gate_allocator_assert.svh =====
// assertion macros for the interrupt gate allocator
`ifndef INTERRUPT_GATE_ALLOCATOR_ASSERT_SVH
`define INTERRUPT_GATE_ALLOCATOR_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define IGA_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interrupt gate allocator check failed");

// consequent must hold in the cycle after the antecedent
`define IGA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interrupt gate allocator check failed");

`endif

// ===== rtl/iga_pkg.sv =====
// shared types, constants and functions of the interrupt gate allocator
`default_nettype none

package iga_pkg;

  localparam int NUM_GATES_DEF   = 256;
  localparam int FIRST_FREE_GATE = 48;
  localparam int WORD_BITS       = 32;
  localparam int BIT_IDX_W       = $clog2(WORD_BITS);

  localparam logic [15:0] KSEL_RESET = 16'd8;

  // operation codes
  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_ALLOC = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_REFUSED   = 2'd1;
  localparam logic [1:0] STATUS_NONE_FREE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_init;
    logic scan_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mode_alloc;
    logic scan_hit;
    logic scan_last;
  } stat_t;

  function automatic logic [63:0] pack_descriptor(input logic [31:0] addr,
                                                  input logic [15:0] sel,
                                                  input logic [7:0]  flags);
    pack_descriptor = {addr[31:16], flags, 8'd0, sel, addr[15:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/iga_ctrl.sv =====
// controller state machine of the interrupt gate allocator
`default_nettype none

module iga_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire iga_pkg::stat_t st,
  output iga_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {IDLE, EXEC, SCAN, DONE} state_t;

  state_t state;
  logic   out_free;

  assign in_ready = (state == IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd = '0;
    unique case (state)
      IDLE: cmd.load = in_valid;
      EXEC: begin
        cmd.scan_init = st.mode_alloc;
        cmd.exec      = !st.mode_alloc;
      end
      SCAN: cmd.scan_step = 1'b1;
      DONE: cmd.out_load = out_free;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // in DONE the output register is either reloaded or left waiting
      if (out_valid && out_ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= EXEC;
          end
        end
        EXEC: state <= st.mode_alloc ? SCAN : DONE;
        SCAN: begin
          if (st.scan_hit || st.scan_last) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iga_datapath.sv =====
// used-bit bitmap, scan unit and result registers of the interrupt gate allocator
`default_nettype none

module iga_datapath #(
  parameter int NUM_GATES = iga_pkg::NUM_GATES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire iga_pkg::cmd_t cmd,
  output iga_pkg::stat_t     st,
  input  wire logic [1:0]    mode,
  input  wire logic [7:0]    gate,
  input  wire logic [31:0]   handler_address,
  input  wire logic [15:0]   code_selector,
  input  wire logic [7:0]    gate_flags,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data,
  output logic [1:0]         status,
  output logic [7:0]         gate_number,
  output logic               write_enable,
  output logic [63:0]        descriptor_word
);

  localparam int NUM_WORDS  = (NUM_GATES + iga_pkg::WORD_BITS - 1) / iga_pkg::WORD_BITS;
  localparam int WI         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int FIRST_WORD = iga_pkg::FIRST_FREE_GATE / iga_pkg::WORD_BITS;
  localparam int BW         = iga_pkg::BIT_IDX_W;

  // latched item
  logic [1:0]  mode_q;
  logic [7:0]  gate_q;
  logic [31:0] addr_q;
  logic [15:0] sel_q;
  logic [7:0]  flags_q;

  logic [15:0] ksel;

  logic [iga_pkg::WORD_BITS-1:0] used_q [NUM_WORDS];
  logic [WI-1:0]                 scan_cnt;

  // pending result
  logic [1:0]  res_status;
  logic [7:0]  res_gate;
  logic        res_we;
  logic [63:0] res_word;

  logic                          in_table;
  logic                          protect;
  logic                          exec_we;
  logic [63:0]                   exec_word;
  logic [iga_pkg::WORD_BITS-1:0] scan_mask;
  logic [iga_pkg::WORD_BITS-1:0] free_bits;
  logic [iga_pkg::WORD_BITS-1:0] lowest;
  logic [BW-1:0]                 hit_idx;
  logic                          wr_en;
  logic [WI-1:0]                 wr_widx;
  logic [BW-1:0]                 wr_bidx;
  logic                          wr_val;

  assign in_table = {1'b0, gate_q} < 9'(NUM_GATES);
  assign protect  = gate_q < 8'(iga_pkg::FIRST_FREE_GATE);

  // result of set, free and unused modes
  always_comb begin
    exec_we   = 1'b0;
    exec_word = '0;
    unique case (mode_q)
      iga_pkg::MODE_SET: begin
        if (in_table) begin
          exec_we   = 1'b1;
          exec_word = iga_pkg::pack_descriptor(addr_q, sel_q, flags_q);
        end
      end
      iga_pkg::MODE_FREE: begin
        if (!protect && in_table) begin
          exec_we   = 1'b1;
          exec_word = iga_pkg::pack_descriptor(32'd0, ksel, 8'd0);
        end
      end
      default: begin
        exec_we   = 1'b0;
        exec_word = '0;
      end
    endcase
  end

  // only gates in the allocatable range count as candidates
  always_comb begin
    for (int b = 0; b < iga_pkg::WORD_BITS; b++) begin
      scan_mask[b] = (9'({scan_cnt, BW'(b)}) >= 9'(iga_pkg::FIRST_FREE_GATE)) &&
                     (9'({scan_cnt, BW'(b)}) <  9'(NUM_GATES));
    end
  end

  assign free_bits = ~used_q[scan_cnt] & scan_mask;
  assign lowest    = free_bits & (~free_bits + 1'b1);

  always_comb begin
    hit_idx = '0;
    for (int b = 0; b < iga_pkg::WORD_BITS; b++) begin
      if (lowest[b]) begin
        hit_idx = hit_idx | BW'(b);
      end
    end
  end

  assign st.mode_alloc = (mode_q == iga_pkg::MODE_ALLOC);
  assign st.scan_hit   = |free_bits;
  assign st.scan_last  = (scan_cnt == WI'(NUM_WORDS - 1));

  // single bitmap write port
  always_comb begin
    wr_en   = 1'b0;
    wr_widx = gate_q[BW +: WI];
    wr_bidx = gate_q[BW-1:0];
    wr_val  = 1'b0;
    if (cmd.exec && exec_we) begin
      wr_en  = 1'b1;
      wr_val = (mode_q == iga_pkg::MODE_SET);
    end
    if (cmd.scan_step && st.scan_hit) begin
      wr_en   = 1'b1;
      wr_widx = scan_cnt;
      wr_bidx = hit_idx;
      wr_val  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        used_q[w] <= '0;
      end
      ksel     <= iga_pkg::KSEL_RESET;
      scan_cnt <= WI'(FIRST_WORD);
    end else begin
      if (wr_en) begin
        used_q[wr_widx][wr_bidx] <= wr_val;
      end
      if (cfg_we) begin
        ksel <= cfg_data;
      end
      if (cmd.scan_init) begin
        scan_cnt <= WI'(FIRST_WORD);
      end else if (cmd.scan_step && !st.scan_hit && !st.scan_last) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode;
      gate_q  <= gate;
      addr_q  <= handler_address;
      sel_q   <= code_selector;
      flags_q <= gate_flags;
    end
    if (cmd.exec) begin
      res_status <= (mode_q == iga_pkg::MODE_FREE && protect) ?
                    iga_pkg::STATUS_REFUSED : iga_pkg::STATUS_DONE;
      res_gate   <= gate_q;
      res_we     <= exec_we;
      res_word   <= exec_word;
    end
    if (cmd.scan_step) begin
      res_we   <= 1'b0;
      res_word <= '0;
      if (st.scan_hit) begin
        res_status <= iga_pkg::STATUS_DONE;
        res_gate   <= 8'({scan_cnt, hit_idx});
      end else begin
        res_status <= iga_pkg::STATUS_NONE_FREE;
        res_gate   <= 8'd0;
      end
    end
    if (cmd.out_load) begin
      status          <= res_status;
      gate_number     <= res_gate;
      write_enable    <= res_we;
      descriptor_word <= res_word;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/interrupt_gate_allocator.sv =====
// top level of the interrupt gate allocator
`default_nettype none

`include "interrupt_gate_allocator_assert.svh"

// Interrupt gate allocator: keeps one used bit per interrupt gate and runs one
// operation per input transfer. Set (mode 0) packs a gate descriptor, emits it
// with write_enable for an external descriptor memory and marks the gate used.
// Free (mode 1) refuses gates below 48 with status 1; otherwise it emits an
// empty descriptor carrying kernel_selector and clears the used bit. Allocate
// (mode 2) returns the lowest unused gate from 48 upward and marks it used, or
// status 2 with gate 0 when every gate is taken. Set or free of a gate beyond
// NUM_GATES, and mode 3, only echo the gate with status 0. Only one item is
// in flight at a time. Allocate scans the 32-bit used words upward from the
// word that holds gate 48, 1 up to ceil(NUM_GATES/32) - 1 words, so at most 7
// for 256 gates; the scan reads one bitmap word per cycle, stops at the first
// word with a free gate, and the words scanned set the allocate latency.
// The next item is taken in the cycle after the result is loaded into the
// output register, even while that result still waits for out_ready.
// kernel_selector resets to 8 and is written through the cfg channel, which
// is always ready.
module interrupt_gate_allocator #(
  parameter int NUM_GATES = iga_pkg::NUM_GATES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] kernel_selector,
  // input item channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  gate,
  input  wire logic [31:0] handler_address,
  input  wire logic [15:0] code_selector,
  input  wire logic [7:0]  gate_flags,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [7:0]       gate_number,
  output logic             write_enable,
  output logic [63:0]      descriptor_word
);

  iga_pkg::cmd_t  cmd;
  iga_pkg::stat_t st;

  // user keeps register writes to idle, unchecked here; the port never stalls
  assign cfg_ready = 1'b1;

  // sequencing: load, execute or scan, then hand off to the output register
  iga_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // bitmap, scan unit, descriptor packing and result registers
  iga_datapath #(
    .NUM_GATES (NUM_GATES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .mode            (mode),
    .gate            (gate),
    .handler_address (handler_address),
    .code_selector   (code_selector),
    .gate_flags      (gate_flags),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (kernel_selector),
    .status          (status),
    .gate_number     (gate_number),
    .write_enable    (write_enable),
    .descriptor_word (descriptor_word)
  );

  // a descriptor write is only ever paired with a successful operation
  `IGA_ASSERT_SAME(a_we_done, clk, rst, out_valid && write_enable,
                   status == iga_pkg::STATUS_DONE)

  // no descriptor content leaks out without a write
  `IGA_ASSERT_SAME(a_word_zero, clk, rst, out_valid && !write_enable,
                   descriptor_word == 64'd0)

  // failed allocation reports gate zero
  `IGA_ASSERT_SAME(a_none_gate, clk, rst,
                   out_valid && status == iga_pkg::STATUS_NONE_FREE,
                   gate_number == 8'd0)

  // one item in flight: an accepted transfer closes the input channel
  `IGA_ASSERT_NEXT(a_one_item, clk, rst, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire
